[rtl/core/ipd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

  // Frame layout defaults
  localparam int BYTES_PER_HALF_DEF     = 4;
  localparam int SECOND_HALF_OFFSET_DEF = 72;

  // Captured durations are masked to this many bits
  localparam int DURATION_BITS = 16;
  localparam int DUR_W         = 16;
  localparam logic [DUR_W-1:0] DUR_MASK =
    (DURATION_BITS >= DUR_W) ? {DUR_W{1'b1}}
                             : DUR_W'((64'd1 << DURATION_BITS) - 64'd1);

  localparam int IDX_W  = 4;
  localparam int BYTE_W = 8;

  // Result queue depth, power of two, at least two
  localparam int QUEUE_DEPTH = 4;

  // Register indexes
  localparam logic [2:0] REG_MARK_MIN       = 3'd0;
  localparam logic [2:0] REG_MARK_MAX       = 3'd1;
  localparam logic [2:0] REG_ZERO_SPACE_MIN = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE_MAX = 3'd3;
  localparam logic [2:0] REG_ONE_SPACE_MIN  = 3'd4;
  localparam logic [2:0] REG_ONE_SPACE_MAX  = 3'd5;
  localparam logic [2:0] REG_FIXED_MIDDLE   = 3'd6;

  typedef struct packed {
    logic [15:0] mark_min;
    logic [15:0] mark_max;
    logic [15:0] zero_space_min;
    logic [15:0] zero_space_max;
    logic [15:0] one_space_min;
    logic [15:0] one_space_max;
    logic [7:0]  fixed_middle_byte;
  } cfg_t;

  typedef struct packed {
    logic              run_last;
    logic [BYTE_W-1:0] byte_value;
    logic [IDX_W-1:0]  byte_index;
  } result_t;

  // Results produced by one accepted item (0, 1 or 2)
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage : ipd_pkg
`default_nettype wire

[rtl/core/ipd_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_datapath
// Frame position, held mark and byte shifter; classifies each duration.
// ----------------------------------------------------------------------------
module ipd_datapath
  import ipd_pkg::*;
#(
  parameter int BYTES_PER_HALF     = BYTES_PER_HALF_DEF,
  parameter int SECOND_HALF_OFFSET = SECOND_HALF_OFFSET_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             accept,
  input  wire logic [DUR_W-1:0] duration,
  input  wire logic             frame_start,
  output push_t                 push
);

  localparam int HALF_LEN  = 16 * BYTES_PER_HALF;
  localparam int FRAME_END = SECOND_HALF_OFFSET + HALF_LEN;
  localparam int POS_W     = $clog2(FRAME_END + 1);

  localparam logic [POS_W-1:0] FRAME_END_P  = POS_W'(FRAME_END);
  localparam logic [POS_W-1:0] HALF_LEN_P   = POS_W'(HALF_LEN);
  localparam logic [POS_W-1:0] HALF_LAST_P  = POS_W'(HALF_LEN - 1);
  localparam logic [POS_W-1:0] OFFSET_P     = POS_W'(SECOND_HALF_OFFSET);
  localparam logic [IDX_W-1:0] IDX_MIDDLE   = IDX_W'(BYTES_PER_HALF);
  localparam logic [IDX_W-1:0] IDX_SEC_BASE = IDX_W'(BYTES_PER_HALF + 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [DUR_W-1:0]  held_mark_r, held_mark_nxt;
  logic [BYTE_W-1:0] shifter_r, shifter_nxt;

  logic [POS_W-1:0]  pos, rel;
  logic [DUR_W-1:0]  dur;
  logic              active, in_first, in_second, taking;
  logic              mark_ok, zero_hit, one_hit, byte_end, last_first;
  logic [BYTE_W-1:0] base, shifted;
  logic [IDX_W-1:0]  idx;

  always_comb begin
    dur       = duration & DUR_MASK;
    pos       = frame_start ? '0 : pos_r;
    active    = pos < FRAME_END_P;
    in_first  = pos < HALF_LEN_P;
    in_second = active && !in_first && (pos >= OFFSET_P);
    taking    = active && (in_first || in_second);
    rel       = in_first ? pos : pos - OFFSET_P;

    mark_ok  = (held_mark_r >= cfg.mark_min) && (held_mark_r <= cfg.mark_max);
    zero_hit = (dur >= cfg.zero_space_min) && (dur <= cfg.zero_space_max);
    one_hit  = (dur >= cfg.one_space_min) && (dur <= cfg.one_space_max);

    // byte register starts clean at each byte boundary
    base = (rel[3:0] == 4'd0) ? '0 : shifter_r;

    // both windows may hit: 0 then 1
    shifted = base;
    if (zero_hit) begin
      shifted = {1'b0, shifted[BYTE_W-1:1]};
    end
    if (one_hit) begin
      shifted = {1'b1, shifted[BYTE_W-1:1]};
    end

    held_mark_nxt = held_mark_r;
    shifter_nxt   = shifter_r;
    if (taking) begin
      if (!rel[0]) begin
        held_mark_nxt = dur;
        shifter_nxt   = base;
      end else if (mark_ok) begin
        shifter_nxt = shifted;
      end else begin
        shifter_nxt = base;
      end
    end

    pos_nxt = active ? pos + POS_W'(1) : pos;

    byte_end   = taking && (rel[3:0] == 4'd15);
    last_first = in_first && (pos == HALF_LAST_P);
    idx        = in_first ? IDX_W'(rel >> 4) : IDX_SEC_BASE + IDX_W'(rel >> 4);

    push.r0.byte_index = idx;
    push.r0.byte_value = shifter_nxt;
    push.r0.run_last   = !last_first;
    push.r1.byte_index = IDX_MIDDLE;
    push.r1.byte_value = cfg.fixed_middle_byte;
    push.r1.run_last   = 1'b1;
    if (!accept || !byte_end) begin
      push.count = 2'd0;
    end else if (last_first) begin
      push.count = 2'd2;
    end else begin
      push.count = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= FRAME_END_P;
      held_mark_r <= '0;
      shifter_r   <= '0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      held_mark_r <= held_mark_nxt;
      shifter_r   <= shifter_nxt;
    end
  end

endmodule : ipd_datapath
`default_nettype wire

[rtl/core/ipd_result_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_result_queue
// Small result queue; takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module ipd_result_queue
  import ipd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       space_ok,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_result
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(QUEUE_DEPTH - 2);

  result_t          q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  always_comb begin
    space_ok   = cnt_r <= ROOM_LIMIT;
    out_valid  = cnt_r != '0;
    out_result = q_r[rd_ptr_r];
    pop        = out_valid && out_ready;
    wr_ptr_p1  = wr_ptr_r + PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.count);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_r[wr_ptr_r] <= push.r0;
    end
    if (push.count == 2'd2) begin
      q_r[wr_ptr_p1] <= push.r1;
    end
  end

endmodule : ipd_result_queue
`default_nettype wire

[rtl/core/ir_pulse_distance_frame_decoder.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result is written into the result queue when the item that ends its byte is accepted.
// Throughput: one duration item per clock while in_tready is high; an item ending the first half
//   yields two results, drained one per clock through a 4-entry result queue.
// in_tready drops only while that queue has fewer than two free entries.
// Reset (rst_n low, synchronous): decoder idle until a frame start, held mark
//   and byte register cleared, queue empty, registers back to defaults.
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Decodes IR mark/space durations into frame bytes, LSB first.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder
  import ipd_pkg::*;
#(
  parameter int BYTES_PER_HALF     = BYTES_PER_HALF_DEF,
  parameter int SECOND_HALF_OFFSET = SECOND_HALF_OFFSET_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] duration
  input  wire logic        in_tuser,    // [0] frame_start
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,   // [3:0] byte_index, [11:4] byte_value, [15:12] 0
  output logic             out_tlast,   // run_last
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t    cfg_r;
  logic    cfg_wr;
  logic    accept;
  logic    space_ok;
  push_t   push;
  result_t res;
  logic [2:0] reg_idx;

  // ---------------------------------------------------------------------------
  // Configuration registers: byte address 4*i, always ready, zero-wait.
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mark_min          <= 16'd480;
      cfg_r.mark_max          <= 16'd680;
      cfg_r.zero_space_min    <= 16'd480;
      cfg_r.zero_space_max    <= 16'd600;
      cfg_r.one_space_min     <= 16'd1450;
      cfg_r.one_space_max     <= 16'd1600;
      cfg_r.fixed_middle_byte <= 8'h02;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MARK_MIN:       cfg_r.mark_min          <= cfg_pwdata[15:0];
        REG_MARK_MAX:       cfg_r.mark_max          <= cfg_pwdata[15:0];
        REG_ZERO_SPACE_MIN: cfg_r.zero_space_min    <= cfg_pwdata[15:0];
        REG_ZERO_SPACE_MAX: cfg_r.zero_space_max    <= cfg_pwdata[15:0];
        REG_ONE_SPACE_MIN:  cfg_r.one_space_min     <= cfg_pwdata[15:0];
        REG_ONE_SPACE_MAX:  cfg_r.one_space_max     <= cfg_pwdata[15:0];
        REG_FIXED_MIDDLE:   cfg_r.fixed_middle_byte <= cfg_pwdata[7:0];
        default: ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MARK_MIN:       cfg_prdata = {16'd0, cfg_r.mark_min};
      REG_MARK_MAX:       cfg_prdata = {16'd0, cfg_r.mark_max};
      REG_ZERO_SPACE_MIN: cfg_prdata = {16'd0, cfg_r.zero_space_min};
      REG_ZERO_SPACE_MAX: cfg_prdata = {16'd0, cfg_r.zero_space_max};
      REG_ONE_SPACE_MIN:  cfg_prdata = {16'd0, cfg_r.one_space_min};
      REG_ONE_SPACE_MAX:  cfg_prdata = {16'd0, cfg_r.one_space_max};
      REG_FIXED_MIDDLE:   cfg_prdata = {24'd0, cfg_r.fixed_middle_byte};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side: an item is taken whenever the queue can absorb the worst case
  // of two results, so the decoder state updates once per accepted item.
  // ---------------------------------------------------------------------------
  assign in_tready = space_ok;
  assign accept    = in_tvalid && in_tready;

  // Position tracking, window compare and byte shift, all combinational ahead of the datapath registers.
  ipd_datapath #(
    .BYTES_PER_HALF     (BYTES_PER_HALF),
    .SECOND_HALF_OFFSET (SECOND_HALF_OFFSET)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .accept      (accept),
    .duration    (in_tdata),
    .frame_start (in_tuser),
    .push        (push)
  );

  // Result queue separates the two sides; the fixed middle byte rides as a
  // second entry written in the same cycle as the last first-half byte.
  ipd_result_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .space_ok   (space_ok),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  assign out_tdata = {4'd0, res.byte_value, res.byte_index};
  assign out_tlast = res.run_last;

endmodule : ir_pulse_distance_frame_decoder
`default_nettype wire

[dv/ipd_byte_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_byte_checker
// Watches the decoder's duration, byte and register traffic, works out each
// decoded byte on its own and compares it with the byte that comes out.
// ----------------------------------------------------------------------------
module ipd_byte_checker
  import ipd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] duration
  input  wire logic        in_tuser,    // [0] frame_start
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] out_tdata,   // [3:0] byte_index, [11:4] byte_value, [15:12] 0
  input  wire logic        out_tlast,   // run_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  output int               mismatches,
  output int               outstanding,
  output int               checked
);

  localparam int HALF_LEN  = 16 * BYTES_PER_HALF_DEF;
  localparam int FRAME_END = SECOND_HALF_OFFSET_DEF + HALF_LEN;

  cfg_t        windows;
  int unsigned position;
  logic [15:0] held_mark;
  logic [7:0]  shifter;
  result_t     expected_bytes[$];
  result_t     got;
  result_t     want;
  int          fails   = 0;
  int          n_bytes = 0;

  function automatic logic in_range(logic [15:0] v, logic [15:0] lo, logic [15:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  // One duration at offset rel inside a half: marks are held, spaces shift.
  task automatic shift_pair(int unsigned rel, logic [15:0] dur);
    if (rel[3:0] == 4'd0) shifter = 8'd0;
    if (!rel[0]) begin
      held_mark = dur;
      return;
    end
    if (!in_range(held_mark, windows.mark_min, windows.mark_max)) return;
    // both windows may hit: zero shift first, then one shift
    if (in_range(dur, windows.zero_space_min, windows.zero_space_max))
      shifter = {1'b0, shifter[7:1]};
    if (in_range(dur, windows.one_space_min, windows.one_space_max))
      shifter = {1'b1, shifter[7:1]};
  endtask

  task automatic emit(int unsigned idx, logic [7:0] val, logic last);
    result_t r;
    r.byte_index = idx[IDX_W-1:0];
    r.byte_value = val;
    r.run_last   = last;
    expected_bytes.push_back(r);
  endtask

  task automatic decode_duration(logic [15:0] raw, logic start);
    logic [15:0] dur;
    int unsigned p;
    int unsigned rel;
    dur = raw & DUR_MASK;
    if (start) position = 0;
    p = position;
    if (p >= FRAME_END) return;   // idle, saturated
    if (p < HALF_LEN) begin
      shift_pair(p, dur);
      if (p[3:0] == 4'hF) begin
        emit(p >> 4, shifter, p != HALF_LEN - 1);
        if (p == HALF_LEN - 1)
          emit(BYTES_PER_HALF_DEF, windows.fixed_middle_byte, 1'b1);
      end
    end else if (p >= SECOND_HALF_OFFSET_DEF) begin
      rel = p - SECOND_HALF_OFFSET_DEF;
      shift_pair(rel, dur);
      if (rel[3:0] == 4'hF)
        emit(BYTES_PER_HALF_DEF + 1 + (rel >> 4), shifter, 1'b1);
    end
    position = p + 1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      windows.mark_min          = 16'd480;
      windows.mark_max          = 16'd680;
      windows.zero_space_min    = 16'd480;
      windows.zero_space_max    = 16'd600;
      windows.one_space_min     = 16'd1450;
      windows.one_space_max     = 16'd1600;
      windows.fixed_middle_byte = 8'h02;
      position  = FRAME_END;
      held_mark = 16'd0;
      shifter   = 8'd0;
      expected_bytes.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_MARK_MIN:       windows.mark_min          = cfg_pwdata[15:0];
          REG_MARK_MAX:       windows.mark_max          = cfg_pwdata[15:0];
          REG_ZERO_SPACE_MIN: windows.zero_space_min    = cfg_pwdata[15:0];
          REG_ZERO_SPACE_MAX: windows.zero_space_max    = cfg_pwdata[15:0];
          REG_ONE_SPACE_MIN:  windows.one_space_min     = cfg_pwdata[15:0];
          REG_ONE_SPACE_MAX:  windows.one_space_max     = cfg_pwdata[15:0];
          REG_FIXED_MIDDLE:   windows.fixed_middle_byte = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      // results leaving now belong to earlier durations: compare first
      if (out_tvalid && out_tready) begin
        got.byte_index = out_tdata[3:0];
        got.byte_value = out_tdata[11:4];
        got.run_last   = out_tlast;
        if (expected_bytes.size() == 0) begin
          fails++;
          $display("%0t: unexpected byte: idx=%0d val=%02h last=%0b",
                   $time, got.byte_index, got.byte_value, got.run_last);
        end else begin
          want = expected_bytes.pop_front();
          n_bytes++;
          if (want !== got) begin
            fails++;
            $display("%0t: byte mismatch: expected idx=%0d val=%02h last=%0b,",
                     $time, want.byte_index, want.byte_value, want.run_last,
                     " got idx=%0d val=%02h last=%0b",
                     got.byte_index, got.byte_value, got.run_last);
          end
        end
      end
      if (in_tvalid && in_tready) decode_duration(in_tdata, in_tuser);
    end
    mismatches  <= fails;
    outstanding <= expected_bytes.size();
    checked     <= n_bytes;
  end

endmodule

[dv/ir_pulse_distance_frame_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_test
// Feeds IR mark/space durations into the frame decoder, mostly as whole
// frames with window-edge values, under several register settings and
// stall patterns; a side checker predicts and compares every byte.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_test;
  import ipd_pkg::*;

  // one whole frame: first half, gap, second half
  localparam int FRAME_LEN = SECOND_HALF_OFFSET_DEF + 16 * BYTES_PER_HALF_DEF;
  localparam int PHASE_BUDGET = 340;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] duration
  logic        in_tuser;    // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;   // [3:0] byte_index, [11:4] byte_value, [15:12] 0
  logic        out_tlast;   // run_last
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int outstanding;
  int checked;

  // stall odds, in percent, for each side
  int send_idle_pct = 27;
  int recv_idle_pct = 69;

  int items_sent    = 0;
  int frames_sent   = 0;
  int settings_used = 1;   // reset values count as the first setting

  // register values as last written, used only to aim the durations
  logic [15:0] reg_copy [0:6];

  always #4 clk = ~clk;

  ir_pulse_distance_frame_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ipd_byte_checker byte_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  // Result side: one fresh ready decision per clock.
  always @(posedge clk)
    out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);

  // Hard stop in case the decoder hangs.
  initial begin
    #2_000_000;
    $display("timeout: decoder stopped making progress");
    $display("[FAIL] regression broken");
    $finish;
  end

  // Offer one duration and hold it until taken. Random gaps go in front, so
  // valid only drops when a gap is chosen; back-to-back items keep it high.
  task automatic push_duration(logic [15:0] dur, logic start);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= dur;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Stop sending and let every predicted byte come out. The first clock lets
  // the checker see the last item; the tail covers items that end no byte.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup clock, then access clock; upper data bits carry junk on purpose.
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom_range(65535, 0)), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    reg_copy[idx] = val;
  endtask

  task automatic apply_settings(logic [15:0] m_lo, logic [15:0] m_hi,
                                logic [15:0] z_lo, logic [15:0] z_hi,
                                logic [15:0] o_lo, logic [15:0] o_hi,
                                logic [7:0]  mid);
    wait_drained();
    write_reg(REG_MARK_MIN,       m_lo);
    write_reg(REG_MARK_MAX,       m_hi);
    write_reg(REG_ZERO_SPACE_MIN, z_lo);
    write_reg(REG_ZERO_SPACE_MAX, z_hi);
    write_reg(REG_ONE_SPACE_MIN,  o_lo);
    write_reg(REG_ONE_SPACE_MAX,  o_hi);
    write_reg(REG_FIXED_MIDDLE,   {8'($urandom_range(255, 0)), mid});
    settings_used++;
  endtask

  // A duration aimed at a window, often right on or just past its edges.
  // An empty window (lo above hi) falls back to anything.
  function automatic logic [15:0] pick_dur(logic [15:0] lo, logic [15:0] hi);
    int r;
    r = $urandom_range(99, 0);
    if (lo > hi || r < 5) return 16'($urandom_range(65535, 0));
    if (r < 10) return lo;
    if (r < 15) return hi;
    if (r < 18) return lo - 16'd1;
    if (r < 21) return hi + 16'd1;
    return 16'($urandom_range(hi, lo));
  endfunction

  // Even offsets are marks, odd ones spaces; mostly well-formed bits.
  function automatic logic [15:0] frame_duration(int k);
    int r;
    r = $urandom_range(99, 0);
    if (k % 2 == 0) begin
      if (r < 85) return pick_dur(reg_copy[REG_MARK_MIN], reg_copy[REG_MARK_MAX]);
      return 16'($urandom_range(65535, 0));
    end
    if (r < 45) return pick_dur(reg_copy[REG_ZERO_SPACE_MIN], reg_copy[REG_ZERO_SPACE_MAX]);
    if (r < 90) return pick_dur(reg_copy[REG_ONE_SPACE_MIN], reg_copy[REG_ONE_SPACE_MAX]);
    return 16'($urandom_range(65535, 0));
  endfunction

  // Frames: most run to the end, some are cut short by the next frame start.
  // Whole frames are sometimes trailed by noise, which the idle decoder drops.
  task automatic run_phase(int budget);
    int done;
    int len;
    int frame_no;
    done     = 0;
    frame_no = 0;
    while (done < budget) begin
      // hold off until the decoder has emptied, always once per phase
      if (frame_no == 1 || $urandom_range(99, 0) < 5) wait_drained();
      len = ($urandom_range(99, 0) < 20) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
      for (int k = 0; k < len; k++) push_duration(frame_duration(k), k == 0);
      done += len;
      frame_no++;
      frames_sent++;
      if (len == FRAME_LEN && $urandom_range(99, 0) < 15)
        repeat ($urandom_range(4, 1)) push_duration(16'($urandom_range(65535, 0)), 1'b0);
    end
  endtask

  initial begin
    logic [15:0] m_lo;
    logic [15:0] z_lo;
    logic [15:0] o_lo;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 16'd0;
    in_tuser    <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= 5'd0;
    cfg_pwdata  <= 32'd0;
    reg_copy[REG_MARK_MIN]       = 16'd480;
    reg_copy[REG_MARK_MAX]       = 16'd680;
    reg_copy[REG_ZERO_SPACE_MIN] = 16'd480;
    reg_copy[REG_ZERO_SPACE_MAX] = 16'd600;
    reg_copy[REG_ONE_SPACE_MIN]  = 16'd1450;
    reg_copy[REG_ONE_SPACE_MAX]  = 16'd1600;
    reg_copy[REG_FIXED_MIDDLE]   = 16'd2;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset windows: mark 480..680, zero 480..600, one 1450..1600.
    // Idle decoder ignores items without a frame start.
    push_duration(16'd0,     1'b0);
    push_duration(16'd65535, 1'b0);
    // first byte: window edges, bad marks and stray spaces give a short byte
    push_duration(16'd600,   1'b1);
    push_duration(16'd500,   1'b0);
    push_duration(16'd680,   1'b0);
    push_duration(16'd1600,  1'b0);
    push_duration(16'd480,   1'b0);
    push_duration(16'd1450,  1'b0);
    push_duration(16'd479,   1'b0);   // mark just under window
    push_duration(16'd500,   1'b0);
    push_duration(16'd600,   1'b0);
    push_duration(16'd601,   1'b0);   // space between the windows
    push_duration(16'd681,   1'b0);   // mark just over window
    push_duration(16'd1500,  1'b0);
    push_duration(16'd600,   1'b0);
    push_duration(16'd480,   1'b0);
    push_duration(16'd600,   1'b0);
    push_duration(16'd1601,  1'b0);   // ends byte 0
    push_duration(16'd65535, 1'b0);
    push_duration(16'd0,     1'b0);
    // frame start in the middle of a frame restarts at offset zero
    push_duration(16'd600,   1'b1);
    push_duration(16'd1449,  1'b0);
    push_duration(16'd600,   1'b0);
    push_duration(16'd1450,  1'b0);
    frames_sent += 2;

    // Sender lightly stalled, receiver heavily stalled.
    run_phase(PHASE_BUDGET);
    m_lo = 16'($urandom_range(500, 300));
    z_lo = 16'($urandom_range(500, 300));
    o_lo = 16'($urandom_range(1400, 1000));
    apply_settings(m_lo, m_lo + 16'($urandom_range(300, 0)),
                   z_lo, z_lo + 16'($urandom_range(200, 0)),
                   o_lo, o_lo + 16'($urandom_range(300, 0)),
                   8'($urandom_range(255, 0)));
    run_phase(PHASE_BUDGET);

    // Roles swapped. Full mark range with overlapping space windows, so
    // some spaces shift twice; then single-value windows, zero at 0, the others at the top.
    send_idle_pct = 69;
    recv_idle_pct = 27;
    apply_settings(16'd0, 16'd65535, 16'd0, 16'd40000, 16'd30000, 16'd65535, 8'hFF);
    run_phase(PHASE_BUDGET);
    apply_settings(16'd65535, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535, 8'h00);
    run_phase(PHASE_BUDGET);

    // No stalls. Mark window pinned at zero, zero window wide open,
    // one window empty.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(16'd0, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd0, 8'h80);
    run_phase(PHASE_BUDGET);

    wait_drained();
    $display("Sent %0d durations in %0d frames across %0d register settings;",
             items_sent, frames_sent, settings_used);
    $display("compared %0d decoded bytes, %0d mismatching, %0d never seen.",
             checked, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
